// ----- src/qbsi_pkg.sv -----
// Shared types and fixed widths for the quadratic Bezier scanline intersection block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package qbsi_pkg;

    localparam int COORD_W  = 32;          // coordinate width
    localparam int SQ_STEPS = 35;          // root bits of the discriminant square root
    localparam int D_W      = 2 * SQ_STEPS; // discriminant width seen by the root unit
    localparam int REM_W    = 40;          // square root partial remainder width
    localparam int NUM_W    = 37;          // signed numerator and denominator width
    localparam int DIV_W    = 37;          // divider remainder width

    // quadratic coefficients plus the x control values
    typedef struct packed {
        logic signed [33:0] a;
        logic signed [33:0] b;
        logic signed [32:0] c;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] x2;
    } coef_t;

    // root qualification flags plus the x control values
    typedef struct packed {
        logic               hit1;
        logic               hit2;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] x2;
    } root_t;

endpackage

`default_nettype wire

// ----- src/qbsi_front.sv -----
// Front end: turns control points and scanline into quadratic coefficients.
// Depends on qbsi_pkg.
`default_nettype none

module qbsi_front (
    input  logic signed [31:0] ctrl0_x,
    input  logic signed [31:0] ctrl0_y,
    input  logic signed [31:0] ctrl1_x,
    input  logic signed [31:0] ctrl1_y,
    input  logic signed [31:0] ctrl2_x,
    input  logic signed [31:0] ctrl2_y,
    input  logic signed [31:0] scan_y,
    output qbsi_pkg::coef_t    coef
);
    import qbsi_pkg::*;

    logic signed [33:0] y0e;
    logic signed [33:0] y1e;
    logic signed [33:0] y2e;

    assign y0e = 34'(ctrl0_y);
    assign y1e = 34'(ctrl1_y);
    assign y2e = 34'(ctrl2_y);

    assign coef.a  = y0e - (y1e <<< 1) + y2e;
    assign coef.b  = (y1e - y0e) <<< 1;
    assign coef.c  = 33'(ctrl0_y) - 33'(scan_y);
    assign coef.x0 = ctrl0_x;
    assign coef.x1 = ctrl1_x;
    assign coef.x2 = ctrl2_x;

endmodule

`default_nettype wire

// ----- src/qbsi_queue.sv -----
// Two-entry queue that decouples the front end from the solver pipeline.
// Depends on qbsi_pkg.
`default_nettype none

module qbsi_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qbsi_pkg::coef_t din,
    input  logic            pop,
    output qbsi_pkg::coef_t dout,
    output logic            full,
    output logic            empty
);
    import qbsi_pkg::*;

    coef_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && cnt_reg == 2'd1) |=> full)
        else $error("queue did not fill");
`endif

endmodule

`default_nettype wire

// ----- src/qbsi_solve.sv -----
// Root solver: discriminant, pipelined square root and pipelined fixed point dividers.
// Depends on qbsi_pkg; produces qualified roots t1, t2 in Q.FRAC.
`default_nettype none

module qbsi_solve #(
    parameter int FRAC = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  qbsi_pkg::coef_t coef,
    output logic            out_vld,
    output qbsi_pkg::root_t root,
    output logic [FRAC:0]   t1,
    output logic [FRAC:0]   t2
);
    import qbsi_pkg::*;

    localparam int NDIV = FRAC + 1;
    localparam logic [FRAC:0] T_ONE = {1'b1, {FRAC{1'b0}}};

    // ---------------- stage 1: magnitudes and partial products
    logic [33:0] ma, mb;
    logic [32:0] mc;
    logic [16:0] mc_h;

    assign ma   = coef.a[33] ? 34'(-coef.a) : 34'(coef.a);
    assign mb   = coef.b[33] ? 34'(-coef.b) : 34'(coef.b);
    assign mc   = coef.c[32] ? 33'(-coef.c) : 33'(coef.c);
    assign mc_h = {1'b0, mc[32:17]};

    logic        s1_vld_reg;
    coef_t       s1_coef_reg;
    logic        s1_neg_reg;
    logic [33:0] bb_hh_reg, bb_hl_reg, bb_ll_reg;
    logic [33:0] ac_hh_reg, ac_hl_reg, ac_lh_reg, ac_ll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_coef_reg <= coef;
            s1_neg_reg  <= coef.a[33] ^ coef.c[32];
            bb_hh_reg   <= mb[33:17] * mb[33:17];
            bb_hl_reg   <= mb[33:17] * mb[16:0];
            bb_ll_reg   <= mb[16:0] * mb[16:0];
            ac_hh_reg   <= ma[33:17] * mc_h;
            ac_hl_reg   <= ma[33:17] * mc[16:0];
            ac_lh_reg   <= ma[16:0] * mc_h;
            ac_ll_reg   <= ma[16:0] * mc[16:0];
        end
    end

    // ---------------- stage 2: discriminant
    logic [67:0]        bb;
    logic [66:0]        ac;
    logic signed [70:0] bbe, p4, dsc;

    assign bb  = (68'(bb_hh_reg) << 34) + (68'(bb_hl_reg) << 18) + 68'(bb_ll_reg);
    assign ac  = (67'(ac_hh_reg) << 34) + ((67'(ac_hl_reg) + 67'(ac_lh_reg)) << 17)
                 + 67'(ac_ll_reg);
    assign bbe = $signed(71'(bb));
    assign p4  = $signed(71'(ac) << 2);
    assign dsc = s1_neg_reg ? bbe + p4 : bbe - p4;

    logic           s2_vld_reg;
    coef_t          s2_coef_reg;
    logic           s2_dpos_reg;
    logic [D_W-1:0] s2_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_coef_reg <= s1_coef_reg;
            s2_dpos_reg <= !dsc[70] && (dsc != 71'sd0);
            s2_d_reg    <= dsc[D_W-1:0];
        end
    end

    // ---------------- square root, one root bit per stage
    logic                sq_vld_reg  [SQ_STEPS];
    coef_t               sq_coef_reg [SQ_STEPS];
    logic                sq_dpos_reg [SQ_STEPS];
    logic [D_W-1:0]      sq_d_reg    [SQ_STEPS];
    logic [REM_W-1:0]    sq_rem_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0] sq_root_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic                vld_in;
        coef_t               coef_in;
        logic                dpos_in;
        logic [D_W-1:0]      d_in;
        logic [REM_W-1:0]    rem_in;
        logic [SQ_STEPS-1:0] root_in;
        logic [REM_W-1:0]    r2, trial;
        logic                take;

        if (k == 0)
        begin : g_first
            assign vld_in  = s2_vld_reg;
            assign coef_in = s2_coef_reg;
            assign dpos_in = s2_dpos_reg;
            assign d_in    = s2_d_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign vld_in  = sq_vld_reg[k-1];
            assign coef_in = sq_coef_reg[k-1];
            assign dpos_in = sq_dpos_reg[k-1];
            assign d_in    = sq_d_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
        end

        assign r2    = {rem_in[REM_W-3:0], d_in[D_W-1-2*k -: 2]};
        assign trial = REM_W'({root_in, 2'b01});
        assign take  = (r2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k] <= 1'b0;
            else if (en)
                sq_vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_coef_reg[k] <= coef_in;
                sq_dpos_reg[k] <= dpos_in;
                sq_d_reg[k]    <= d_in;
                sq_rem_reg[k]  <= take ? r2 - trial : r2;
                sq_root_reg[k] <= {root_in[SQ_STEPS-2:0], take};
            end
        end
    end

    // ---------------- stage C: numerators, denominator, early range checks
    coef_t                  cq;
    logic                   lin;
    logic signed [NUM_W-1:0] be, ce, ae2, sde, num1, num2, den;
    logic [DIV_W-1:0]       mn1, mn2, md;
    logic                   ok1, ok2;

    assign cq   = sq_coef_reg[SQ_STEPS-1];
    assign lin  = (cq.a == 34'sd0);
    assign be   = NUM_W'(cq.b);
    assign ce   = NUM_W'(cq.c);
    assign ae2  = NUM_W'(cq.a) <<< 1;
    assign sde  = $signed(NUM_W'(sq_root_reg[SQ_STEPS-1]));
    assign num1 = lin ? -ce : -be - sde;
    assign num2 = -be + sde;
    assign den  = lin ? be : ae2;
    assign mn1  = num1[NUM_W-1] ? DIV_W'(-num1) : DIV_W'(num1);
    assign mn2  = num2[NUM_W-1] ? DIV_W'(-num2) : DIV_W'(num2);
    assign md   = den[NUM_W-1] ? DIV_W'(-den) : DIV_W'(den);

    // keep a root only if its quotient is below two and not negative
    assign ok1 = sq_dpos_reg[SQ_STEPS-1] && (mn1 < {md[DIV_W-2:0], 1'b0})
                 && (!(num1[NUM_W-1] ^ den[NUM_W-1]) || (num1 == '0));
    assign ok2 = sq_dpos_reg[SQ_STEPS-1] && !lin && (mn2 < {md[DIV_W-2:0], 1'b0})
                 && (!(num2[NUM_W-1] ^ den[NUM_W-1]) || (num2 == '0));

    logic             c_vld_reg;
    root_t            c_root_reg;
    logic [DIV_W-1:0] c_rem1_reg, c_rem2_reg, c_md_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= sq_vld_reg[SQ_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_root_reg <= '{hit1: ok1, hit2: ok2, x0: cq.x0, x1: cq.x1, x2: cq.x2};
            c_rem1_reg <= mn1;
            c_rem2_reg <= mn2;
            c_md_reg   <= md;
        end
    end

    // ---------------- restoring dividers, one quotient bit per stage
    logic             dv_vld_reg  [NDIV];
    root_t            dv_root_reg [NDIV];
    logic [DIV_W-1:0] dv_md_reg   [NDIV];
    logic [DIV_W-1:0] dv_rem1_reg [NDIV];
    logic [DIV_W-1:0] dv_rem2_reg [NDIV];
    logic [FRAC:0]    dv_q1_reg   [NDIV];
    logic [FRAC:0]    dv_q2_reg   [NDIV];

    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        logic             vld_in;
        root_t            root_in;
        logic [DIV_W-1:0] md_in, rem1_in, rem2_in, r1, r2;
        logic [FRAC:0]    q1_in, q2_in;
        logic             ge1, ge2;

        if (j == 0)
        begin : g_first
            assign vld_in  = c_vld_reg;
            assign root_in = c_root_reg;
            assign md_in   = c_md_reg;
            assign rem1_in = c_rem1_reg;
            assign rem2_in = c_rem2_reg;
            assign q1_in   = '0;
            assign q2_in   = '0;
        end
        else
        begin : g_next
            assign vld_in  = dv_vld_reg[j-1];
            assign root_in = dv_root_reg[j-1];
            assign md_in   = dv_md_reg[j-1];
            assign rem1_in = dv_rem1_reg[j-1];
            assign rem2_in = dv_rem2_reg[j-1];
            assign q1_in   = dv_q1_reg[j-1];
            assign q2_in   = dv_q2_reg[j-1];
        end

        assign ge1 = (rem1_in >= md_in);
        assign ge2 = (rem2_in >= md_in);
        assign r1  = ge1 ? rem1_in - md_in : rem1_in;
        assign r2  = ge2 ? rem2_in - md_in : rem2_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j] <= 1'b0;
            else if (en)
                dv_vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_root_reg[j] <= root_in;
                dv_md_reg[j]   <= md_in;
                dv_rem1_reg[j] <= {r1[DIV_W-2:0], 1'b0};
                dv_rem2_reg[j] <= {r2[DIV_W-2:0], 1'b0};
                dv_q1_reg[j]   <= {q1_in[FRAC-1:0], ge1};
                dv_q2_reg[j]   <= {q2_in[FRAC-1:0], ge2};
            end
        end
    end

    root_t rl;

    assign rl      = dv_root_reg[NDIV-1];
    assign out_vld = dv_vld_reg[NDIV-1];
    assign t1      = dv_q1_reg[NDIV-1];
    assign t2      = dv_q2_reg[NDIV-1];
    assign root    = '{hit1: rl.hit1 && (t1 <= T_ONE), hit2: rl.hit2 && (t2 <= T_ONE),
                       x0: rl.x0, x1: rl.x1, x2: rl.x2};

endmodule

`default_nettype wire

// ----- src/qbsi_eval.sv -----
// Back end: evaluates crossing x by two de Casteljau steps for both roots.
// Depends on qbsi_pkg; three register stages.
`default_nettype none

module qbsi_eval #(
    parameter int FRAC = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  qbsi_pkg::root_t    root,
    input  logic [FRAC:0]      t1,
    input  logic [FRAC:0]      t2,
    output logic               out_vld,
    output logic               hit_first,
    output logic               hit_second,
    output logic signed [31:0] cross_x_first,
    output logic signed [31:0] cross_x_second
);
    import qbsi_pkg::*;

    localparam int PW = FRAC + 34;
    localparam logic [FRAC:0] T_ONE = {1'b1, {FRAC{1'b0}}};

    logic e1_vld_reg, e2_vld_reg, e3_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_vld_reg <= in_vld;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
        end
    end

    logic               hit_o [2];
    logic signed [31:0] x_o   [2];

    for (genvar g = 0; g < 2; g++)
    begin : g_lane
        logic [FRAC:0]         t_in;
        logic                  hit_in;
        logic [FRAC:0]         u_in;
        logic signed [FRAC+1:0] us_in, ts_in;
        logic signed [PW-1:0]  pu0, pt1, pu1, pt2;

        logic signed [PW-1:0]  e1_pu0_reg, e1_pt1_reg, e1_pu1_reg, e1_pt2_reg;
        logic signed [FRAC+1:0] e1_u_reg, e1_t_reg;
        logic                  e1_hit_reg;

        logic signed [PW:0]    s01, s12, sh01, sh12;
        logic signed [31:0]    e2_p01_reg, e2_p12_reg;
        logic signed [FRAC+1:0] e2_u_reg, e2_t_reg;
        logic                  e2_hit_reg;

        logic signed [PW-1:0]  qu, qt;
        logic signed [PW-1:0]  e3_qu_reg, e3_qt_reg;
        logic                  e3_hit_reg;
        logic signed [PW:0]    sx, shx;

        assign t_in   = (g == 0) ? t1 : t2;
        assign hit_in = (g == 0) ? root.hit1 : root.hit2;
        assign u_in   = T_ONE - t_in;
        assign us_in  = $signed({1'b0, u_in});
        assign ts_in  = $signed({1'b0, t_in});
        assign pu0    = us_in * root.x0;
        assign pt1    = ts_in * root.x1;
        assign pu1    = us_in * root.x1;
        assign pt2    = ts_in * root.x2;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e1_pu0_reg <= pu0;
                e1_pt1_reg <= pt1;
                e1_pu1_reg <= pu1;
                e1_pt2_reg <= pt2;
                e1_u_reg   <= us_in;
                e1_t_reg   <= ts_in;
                e1_hit_reg <= hit_in;
            end
        end

        // floor division by 2**FRAC: arithmetic shift
        assign s01  = (PW+1)'(e1_pu0_reg) + (PW+1)'(e1_pt1_reg);
        assign s12  = (PW+1)'(e1_pu1_reg) + (PW+1)'(e1_pt2_reg);
        assign sh01 = s01 >>> FRAC;
        assign sh12 = s12 >>> FRAC;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e2_p01_reg <= sh01[31:0];
                e2_p12_reg <= sh12[31:0];
                e2_u_reg   <= e1_u_reg;
                e2_t_reg   <= e1_t_reg;
                e2_hit_reg <= e1_hit_reg;
            end
        end

        assign qu = e2_u_reg * e2_p01_reg;
        assign qt = e2_t_reg * e2_p12_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e3_qu_reg  <= qu;
                e3_qt_reg  <= qt;
                e3_hit_reg <= e2_hit_reg;
            end
        end

        assign sx       = (PW+1)'(e3_qu_reg) + (PW+1)'(e3_qt_reg);
        assign shx      = sx >>> FRAC;
        assign hit_o[g] = e3_hit_reg;
        assign x_o[g]   = e3_hit_reg ? shx[31:0] : 32'sd0;
    end

    assign out_vld        = e3_vld_reg;
    assign hit_first      = hit_o[0];
    assign hit_second     = hit_o[1];
    assign cross_x_first  = x_o[0];
    assign cross_x_second = x_o[1];

endmodule

`default_nettype wire

// ----- src/quad_bezier_scanline_intersection.sv -----
// Top level of the quadratic Bezier scanline intersection block.
// Depends on qbsi_pkg, qbsi_front, qbsi_queue, qbsi_solve and qbsi_eval.
//
// Accepts one curve/scanline item per clock, unless the output stalls, and returns one result
// item per item, in order. Throughput is one item per cycle while the output does not stall.
// From the accepting edge to m_tvalid an item passes the queue, two discriminant stages, the
// 35-stage square root, one numerator stage, the COORD_FRAC_BITS + 1 stage dividers, three
// evaluation stages and the output register.
// A two-entry queue sits after the coefficient front end; the solver and evaluator stall
// together while the output register holds an item that has not been taken.
`default_nettype none

module quad_bezier_scanline_intersection #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, scan_y
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cross_x_first, cross_x_second
    output logic [63:0]  m_tdata,
    // hit_first, hit_second
    output logic [1:0]   m_tuser
);
    import qbsi_pkg::*;

    coef_t                  coef_in, coef_q;
    logic                   q_full, q_empty, push, pop, en;
    logic                   sv_vld;
    root_t                  sv_root;
    logic [COORD_FRAC_BITS:0] sv_t1, sv_t2;
    logic                   ev_vld, ev_h1, ev_h2;
    logic signed [31:0]     ev_x1, ev_x2;

    logic                   m_vld_reg;
    logic [63:0]            m_data_reg;
    logic [1:0]             m_user_reg;

    qbsi_front u_front (
        .ctrl0_x (s_tdata[31:0]),
        .ctrl0_y (s_tdata[63:32]),
        .ctrl1_x (s_tdata[95:64]),
        .ctrl1_y (s_tdata[127:96]),
        .ctrl2_x (s_tdata[159:128]),
        .ctrl2_y (s_tdata[191:160]),
        .scan_y  (s_tdata[223:192]),
        .coef    (coef_in)
    );

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;
    assign en       = !m_vld_reg || m_tready;
    assign pop      = en && !q_empty;

    qbsi_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (coef_in),
        .pop   (pop),
        .dout  (coef_q),
        .full  (q_full),
        .empty (q_empty)
    );

    qbsi_solve #(.FRAC(COORD_FRAC_BITS)) u_solve (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (pop),
        .coef    (coef_q),
        .out_vld (sv_vld),
        .root    (sv_root),
        .t1      (sv_t1),
        .t2      (sv_t2)
    );

    qbsi_eval #(.FRAC(COORD_FRAC_BITS)) u_eval (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_vld         (sv_vld),
        .root           (sv_root),
        .t1             (sv_t1),
        .t2             (sv_t2),
        .out_vld        (ev_vld),
        .hit_first      (ev_h1),
        .hit_second     (ev_h2),
        .cross_x_first  (ev_x1),
        .cross_x_second (ev_x2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= ev_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= {ev_x2, ev_x1};
            m_user_reg <= {ev_h2, ev_h1};
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    a_x1_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
        else $error("first crossing x not cleared on miss");
    a_x2_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[63:32] == 32'd0))
        else $error("second crossing x not cleared on miss");
`endif

endmodule

`default_nettype wire
